### rtl/bucketed_hash_table_by_year_unit_assert.svh
// Assertion macros for the bucketed hash table
`ifndef BUCKETED_HASH_TABLE_BY_YEAR_UNIT_ASSERT_SVH
`define BUCKETED_HASH_TABLE_BY_YEAR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define BHT_ASSERT(label, clk, rst_n, prop, msg)
`define BHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Types and constants of the bucketed hash table.
// ----------------------------------------------------------------------------
package bht_pkg;
	localparam int NumBuckets  = 16;
	localparam int BucketDepth = 8;
	localparam int BW = $clog2(NumBuckets);
	localparam int SW = $clog2(BucketDepth);
	localparam int FW = $clog2(BucketDepth + 1);
	localparam int AW = BW + SW;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_DEL_IY = 3'd1;
	localparam logic [2:0] ACT_DEL_ID = 3'd2;
	localparam logic [2:0] ACT_LOOKUP = 3'd3;
	localparam logic [2:0] ACT_CHANGE = 3'd4;

	localparam logic [2:0] ST_DONE       = 3'd0;
	localparam logic [2:0] ST_MATCH      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_NO_BUCKETS = 3'd4;

	typedef struct packed {
		logic [15:0] id;
		logic [11:0] year;
		logic [31:0] name;
	} rec_t;
endpackage

### rtl/bucketed_hash_table_by_year_unit.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table_by_year_unit
// Hash table of records in year buckets, one action per request.
// ----------------------------------------------------------------------------
// Channels: a request (action, entry_id, year, new_year, name_ref) under
// in_valid/in_ready; results (status, out_id, out_year, out_name_ref, last)
// under out_valid/out_ready; bucket_count written under cfg_valid/cfg_ready.
// Each request yields one result, but a lookup yields one per match, up
// to eight, the final one marked by last.
// Slots live in one single-port memory with a registered read. After the
// accepting edge, the year and new year are reduced modulo bucket count
// (one remainder bit per cycle). An insert then checks the fill and appends.
// Delete, lookup and change read and check each slot scanned; a removal
// shifts each later slot down by a read and a write, a change then
// appends, and a lookup emits each result. Delete by id scans every active
// bucket (up to 16 x 8 slots). One request is in work at a time.
// Reset empties all buckets and sets bucket_count to 16.
// A stalled receiver holds the result register; in_ready stays low and the
// lookup scan waits at each further match until the result is taken.
// ----------------------------------------------------------------------------
module bucketed_hash_table_by_year_unit import bht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  bucket_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [15:0] entry_id,
	input  logic [11:0] year,
	input  logic [11:0] new_year,
	input  logic [31:0] name_ref,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] out_id,
	output logic [11:0] out_year,
	output logic [31:0] out_name_ref,
	output logic        last
);
`include "bucketed_hash_table_by_year_unit_assert.svh"

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MOD   = 10'b0000000010,
		S_DISP  = 10'b0000000100,
		S_RD    = 10'b0000001000,
		S_CHK   = 10'b0000010000,
		S_SHRD  = 10'b0000100000,
		S_SHWR  = 10'b0001000000,
		S_APPND = 10'b0010000000,
		S_RESP  = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [4:0]  cnt_q;
	logic [2:0]  act_q;
	logic [15:0] id_q;
	logic [11:0] yr_q, nyr_q;
	logic [31:0] nm_q;
	logic [11:0] ysh_q, nysh_q;
	logic [BW-1:0] rem_q, nrem_q;
	logic [3:0]  mod_cnt_q;
	logic [BW-1:0] b_q, nb_q;
	logic [FW-1:0] i_q;
	logic [FW-1:0] fill_q [NumBuckets];
	logic [3:0]  k_q;
	logic        found_q, last_pend_q;
	rec_t        rd_q, mv_q;
	rec_t        mem [NumBuckets*BucketDepth];
	logic        we, re;
	logic [AW-1:0] wa, ra;
	rec_t        wd;
	logic [4:0]  n;
	logic        hit;
	logic [FW-1:0] fb;
	logic [BW:0] rs, ns, rs_red, ns_red;
	logic        load_out;

	assign n = (cnt_q > 5'(NumBuckets)) ? 5'(NumBuckets) : cnt_q;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !out_valid;
	assign fb = fill_q[b_q];
	assign load_out = (state_q == S_RESP || state_q == S_EMIT) && (!out_valid || out_ready);

	assign rs = {rem_q, ysh_q[11]};
	assign ns = {nrem_q, nysh_q[11]};
	assign rs_red = (rs >= n) ? rs - n : rs;
	assign ns_red = (ns >= n) ? ns - n : ns;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_comb begin
		hit = (rd_q.id == id_q) && ((act_q == ACT_DEL_ID) || (rd_q.year == yr_q));
		we = 1'b0; re = 1'b0; wa = '0; ra = '0; wd = '0;
		unique case (state_q)
			S_RD: begin re = 1'b1; ra = {b_q, SW'(i_q)}; end
			S_SHRD: begin re = 1'b1; ra = {b_q, SW'(i_q + FW'(1))}; end
			S_SHWR: begin we = 1'b1; wa = {b_q, SW'(i_q)}; wd = rd_q; end
			S_APPND: begin
				we = 1'b1;
				if (act_q == ACT_INSERT) begin
					wa = {b_q, SW'(fb)}; wd = '{id_q, yr_q, nm_q};
				end else if (nb_q == b_q) begin
					wa = {b_q, SW'(i_q)}; wd = mv_q;
				end else begin
					wa = {nb_q, SW'(fill_q[nb_q])}; wd = mv_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 5'd16;
			for (int j = 0; j < NumBuckets; j++) fill_q[j] <= '0;
		end else begin
			if (cfg_valid && cfg_ready) cnt_q <= bucket_count;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					act_q <= action; id_q <= entry_id; yr_q <= year;
					nyr_q <= new_year; nm_q <= name_ref;
					ysh_q <= year; nysh_q <= new_year;
					rem_q <= '0; nrem_q <= '0; mod_cnt_q <= '0;
					k_q <= '0; found_q <= 1'b0; last_pend_q <= 1'b0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (n == 5'd0) begin
						status <= ST_NO_BUCKETS; state_q <= S_RESP;
					end else begin
						rem_q <= rs_red[BW-1:0];
						nrem_q <= ns_red[BW-1:0];
						ysh_q <= {ysh_q[10:0], 1'b0};
						nysh_q <= {nysh_q[10:0], 1'b0};
						mod_cnt_q <= mod_cnt_q + 4'd1;
						if (mod_cnt_q == 4'd11) begin
							b_q <= (act_q == ACT_DEL_ID) ? '0 : rs_red[BW-1:0];
							nb_q <= ns_red[BW-1:0];
							i_q <= '0;
							state_q <= S_DISP;
						end
					end
				end
				S_DISP: begin
					unique case (act_q) inside
						ACT_INSERT:
							if (fb >= FW'(BucketDepth)) begin
								status <= ST_FULL; state_q <= S_RESP;
							end else state_q <= S_APPND;
						ACT_DEL_IY, ACT_DEL_ID, ACT_LOOKUP, ACT_CHANGE:
							if (i_q < fb && !(act_q == ACT_LOOKUP && k_q == 4'd8))
								state_q <= S_RD;
							else if (act_q == ACT_DEL_ID && 5'(b_q) + 5'd1 < n) begin
								b_q <= b_q + BW'(1); i_q <= '0;
							end else if (act_q == ACT_LOOKUP && found_q) begin
								state_q <= S_EMIT; last_pend_q <= 1'b1;
							end else begin
								status <= ST_NOT_FOUND; state_q <= S_RESP;
							end
						default: begin status <= ST_NOT_FOUND; state_q <= S_RESP; end
					endcase
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (act_q == ACT_LOOKUP) begin
						if (rd_q.year == yr_q && found_q) begin
							state_q <= S_EMIT;
						end else begin
							if (rd_q.year == yr_q) begin
								found_q <= 1'b1; mv_q <= rd_q; k_q <= k_q + 4'd1;
							end
							i_q <= i_q + FW'(1);
							state_q <= S_DISP;
						end
					end else if (hit) begin
						mv_q <= '{rd_q.id, nyr_q, rd_q.name};
						if (act_q == ACT_CHANGE && nb_q == b_q) state_q <= S_APPND;
						else if (act_q == ACT_CHANGE &&
							fill_q[nb_q] >= FW'(BucketDepth)) begin
							status <= ST_FULL; state_q <= S_RESP;
						end else if (i_q + FW'(1) < fb) state_q <= S_SHRD;
						else begin
							fill_q[b_q] <= fb - FW'(1);
							status <= ST_DONE;
							state_q <= (act_q == ACT_CHANGE) ? S_APPND : S_RESP;
						end
					end else begin
						i_q <= i_q + FW'(1);
						state_q <= S_DISP;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					i_q <= i_q + FW'(1);
					if (i_q + FW'(2) < fb) state_q <= S_SHRD;
					else begin
						fill_q[b_q] <= fb - FW'(1);
						status <= ST_DONE;
						state_q <= (act_q == ACT_CHANGE) ? S_APPND : S_RESP;
					end
				end
				S_APPND: begin
					if (act_q == ACT_INSERT) fill_q[b_q] <= fb + FW'(1);
					else if (nb_q != b_q) fill_q[nb_q] <= fill_q[nb_q] + FW'(1);
					status <= ST_DONE; state_q <= S_RESP;
				end
				S_RESP: if (!out_valid || out_ready) begin
					out_id <= '0; out_year <= '0; out_name_ref <= '0; last <= 1'b1;
					state_q <= S_IDLE;
				end
				S_EMIT: if (!out_valid || out_ready) begin
					status <= ST_MATCH;
					out_id <= mv_q.id; out_year <= mv_q.year; out_name_ref <= mv_q.name;
					last <= last_pend_q;
					if (last_pend_q) state_q <= S_IDLE;
					else begin
						mv_q <= rd_q; k_q <= k_q + 4'd1; i_q <= i_q + FW'(1);
						state_q <= S_DISP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BHT_ASSERT(a_no_accept_busy, clk, arst_n, !(in_ready && state_q != S_IDLE), "ready while busy")
	`BHT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`BHT_ASSERT(a_fill_max, clk, arst_n, fb <= FW'(BucketDepth), "bucket overfilled")
	`BHT_ASSERT_NEXT(a_accept_work, clk, arst_n, in_valid && in_ready, state_q == S_MOD,
		"request not started")
endmodule
